### design/gpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and the dimension clamp for the grid path counter.
// No dependencies; used by every module in this folder.
package gpc_pkg;

	localparam int MAX_DIM = 32;
	localparam int DIM_W   = 6;                  // holds 1..MAX_DIM
	localparam int IDX_W   = $clog2(MAX_DIM);    // column index
	localparam int CNT_W   = 59;                 // path count width
	localparam int STEP_W  = $clog2(2 * MAX_DIM); // wavefront step counter
	localparam int IN_W    = 16;                 // input word, byte padded
	localparam int OUT_W   = 64;                 // output word, byte padded

	// row token handed down the cell chain
	typedef struct packed {
		logic act;    // this cell updates in this cycle
		logic first;  // first row: copy left instead of adding
	} gpc_tok_t;

	typedef logic [CNT_W-1:0] gpc_cnt_t;

	// zero counts as one, anything above MAX_DIM saturates
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

endpackage

### design/gpc_cell.sv
`timescale 1ns / 1ps
// One column cell: holds the running column sum and forwards the row token.
// Depends on gpc_pkg.
module gpc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  gpc_pkg::gpc_tok_t tok_in,
	input  gpc_pkg::gpc_cnt_t left,
	output gpc_pkg::gpc_tok_t tok_out,
	output gpc_pkg::gpc_cnt_t sum
);
	import gpc_pkg::*;

	gpc_tok_t tok_q;
	gpc_cnt_t sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	// cell above plus cell to the left; first row just copies the left cell
	always_ff @(posedge clk) begin
		if (tok_in.act) begin
			sum_q <= tok_in.first ? left : sum_q + left;
		end
	end

	assign tok_out = tok_q;
	assign sum     = sum_q;

endmodule

### design/gpc_seq.sv
`timescale 1ns / 1ps
// Item sequencer: takes a grid size, injects row tokens into the cell chain,
// picks up the finished count into the output register. Depends on gpc_pkg.
module gpc_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [gpc_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [gpc_pkg::OUT_W-1:0] m_axis_tdata,
	output gpc_pkg::gpc_tok_t         tok,
	output logic [gpc_pkg::IDX_W-1:0] col_sel,
	input  gpc_pkg::gpc_cnt_t         result
);
	import gpc_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t             state_q;
	logic [DIM_W-1:0]   rows_q;
	logic [DIM_W-1:0]   cols_q;
	logic [STEP_W-1:0]  step_q;
	logic [STEP_W-1:0]  last_step_q;
	logic               out_valid_q;
	gpc_cnt_t           out_data_q;

	logic [DIM_W-1:0]   rows_c;
	logic [DIM_W-1:0]   cols_c;
	logic [DIM_W:0]     last_sum;
	logic               in_acc;
	logic               done;

	assign rows_c   = clamp_dim(s_axis_tdata[DIM_W-1:0]);
	assign cols_c   = clamp_dim(s_axis_tdata[2*DIM_W-1:DIM_W]);
	// last step index: the result of the last cell has settled by this step
	assign last_sum = {1'b0, rows_c} + {1'b0, cols_c} - (DIM_W+1)'(2);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign done          = (state_q == ST_RUN) && (step_q == last_step_q)
	                       && (!out_valid_q || m_axis_tready);

	assign tok.act   = (state_q == ST_RUN) && (STEP_W'(rows_q) > step_q);
	assign tok.first = (state_q == ST_RUN) && (step_q == '0);
	assign col_sel   = IDX_W'(cols_q - DIM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (done)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (done) begin
						state_q <= ST_IDLE;
					end else if (step_q != last_step_q) begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rows_q      <= rows_c;
			cols_q      <= cols_c;
			last_step_q <= STEP_W'(last_sum);
		end
		if (done)
			out_data_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W-CNT_W){1'b0}}, out_data_q};

	a_first_is_act: assert property (@(posedge clk) disable iff (!arst_n)
		tok.first |-> tok.act) else $error("first-row token without active flag");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= STEP_W'(2 * MAX_DIM - 2)))
		else $error("wavefront step out of range");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RUN) && (step_q == '0))
		else $error("accepted word did not start a run");
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q != '0)) else $error("path count of zero");

endmodule

### design/grid_path_count_dp_core.sv
`timescale 1ns / 1ps
// Top level of the grid path counter: sequencer plus a chain of column cells.
// Depends on gpc_pkg, gpc_seq, gpc_cell.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata: grid_rows[5:0], grid_cols[11:6]
//  m_axis    out  m_axis_tvalid/tready    tdata: path_count[58:0]
//
// The wavefront crosses the chain one cell per cycle for each row.
// One grid at a time; the next word is taken once the count has moved to the
// output register, which may still be waiting on m_axis_tready.
// arst_n clears control and tokens; column sums are rebuilt by every grid.
module grid_path_count_dp_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [gpc_pkg::IN_W-1:0]  s_axis_tdata,   // grid_rows, grid_cols
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [gpc_pkg::OUT_W-1:0] m_axis_tdata    // path_count
);
	import gpc_pkg::*;

	gpc_tok_t              tok [MAX_DIM];
	gpc_cnt_t              sums [MAX_DIM];
	logic [IDX_W-1:0]      col_sel;
	gpc_cnt_t              result;

	// column 0 is the seed column and is always one
	assign sums[0] = CNT_W'(1);

	gpc_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.tok           (tok[0]),
		.col_sel       (col_sel),
		.result        (result)
	);

	for (genvar c = 1; c < MAX_DIM; c++) begin : g_cell
		gpc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[c-1]),
			.left    (sums[c-1]),
			.tok_out (tok[c]),
			.sum     (sums[c])
		);
	end

	assign result = sums[col_sel];

endmodule

### tb/tb_grid_path_count_dp_core.sv
`timescale 1ns / 1ps
// Testbench for grid_path_count_dp_core: corner and random grid sizes go in, path counts
// are checked against a column-sum predictor kept in a small scoreboard class.
// Depends on gpc_pkg and grid_path_count_dp_core.
module tb_grid_path_count_dp_core;

	localparam int N_RANDOM = 1700;

	class path_count_board;
		logic [63:0]       column_sums [gpc_pkg::MAX_DIM];
		gpc_pkg::gpc_cnt_t expected_counts [$];
		int unsigned       mismatches;

		function new();
			mismatches = 0;
			foreach (column_sums[k])
				column_sums[k] = '0;
		endfunction

		// zero reads as one, oversize saturates
		function int unsigned fit_dim(input logic [5:0] v);
			if (v == 6'd0)
				return 1;
			if (v > 6'(gpc_pkg::MAX_DIM))
				return gpc_pkg::MAX_DIM;
			return int'(v);
		endfunction

		function void note_grid(input logic [5:0] rows_in, input logic [5:0] cols_in);
			int unsigned rows;
			int unsigned cols;
			logic [63:0] corner;
			rows = fit_dim(rows_in);
			cols = fit_dim(cols_in);
			column_sums[0] = 64'd1;
			for (int c = 1; c < cols; c++)
				column_sums[c] = column_sums[c-1];
			for (int r = 1; r < rows; r++)
				for (int c = 1; c < cols; c++)
					column_sums[c] = column_sums[c] + column_sums[c-1];
			corner = column_sums[cols-1];
			expected_counts.push_back(corner[gpc_pkg::CNT_W-1:0]);
		endfunction

		task report_mismatch(input string what, input gpc_pkg::gpc_cnt_t got,
				input gpc_pkg::gpc_cnt_t want);
			if (mismatches < 40)
				$display("mismatch: %s: path_count got %0d want %0d", what, got, want);
			mismatches++;
		endtask

		task check_count(input gpc_pkg::gpc_cnt_t got);
			gpc_pkg::gpc_cnt_t want;
			if (expected_counts.size() == 0) begin
				report_mismatch("output word with no grid pending", got, '0);
			end else begin
				want = expected_counts.pop_front();
				if (got !== want)
					report_mismatch("wrong count", got, want);
			end
		endtask
	endclass

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [gpc_pkg::IN_W-1:0]  s_axis_tdata  = '0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [gpc_pkg::OUT_W-1:0] m_axis_tdata;

	path_count_board board = new();

	int unsigned burst_left;
	int unsigned stall_left = 0;
	int unsigned calm_left  = 0;

	logic [5:0] corner_rows [25] = '{1, 0, 0, 7, 1, 32, 32, 31, 32, 63, 33, 33, 2,
		63, 2, 3, 16, 40, 5, 1, 20, 10, 32, 2, 0};
	logic [5:0] corner_cols [25] = '{1, 0, 7, 0, 32, 1, 32, 32, 31, 63, 33, 1, 63,
		2, 2, 3, 17, 5, 40, 20, 1, 10, 2, 32, 32};

	always #4 clk = ~clk;

	grid_path_count_dp_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // grid_rows[5:0], grid_cols[11:6]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)    // path_count[58:0]
	);

	// holds valid until the word is taken; valid stays high for the next call
	task automatic send_grid(input logic [5:0] rows, input logic [5:0] cols);
		s_axis_tdata  <= {4'b0000, cols, rows};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_in_bursts(input logic [5:0] rows, input logic [5:0] cols);
		send_grid(rows, cols);
		burst_left--;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 70))
					@(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// mostly legal sizes, some zero/oversize, some extremes
	function automatic logic [5:0] pick_dim();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 80)
			return 6'($urandom_range(1, gpc_pkg::MAX_DIM));
		if (sel < 90)
			return 6'($urandom_range(0, 63));
		if (sel < 95)
			return 6'd1;
		return 6'(gpc_pkg::MAX_DIM);
	endfunction

	// receiver: calm stretches, random stalls of various lengths
	always @(posedge clk) begin
		if (calm_left != 0) begin
			calm_left--;
			m_axis_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			case ($urandom_range(0, 9))
				0: calm_left = $urandom_range(100, 600);
				1, 2, 3: stall_left = $urandom_range(1, 40);
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note_grid(s_axis_tdata[5:0], s_axis_tdata[11:6]);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_count(m_axis_tdata[gpc_pkg::CNT_W-1:0]);
	end

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 40);
		for (int i = 0; i < 25; i++)
			send_in_bursts(corner_rows[i], corner_cols[i]);
		for (int i = 0; i < N_RANDOM; i++)
			send_in_bursts(pick_dim(), pick_dim());
		s_axis_tvalid <= 1'b0;
		while (board.expected_counts.size() != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
		if (board.mismatches == 0 && board.expected_counts.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
